// ===== hw/rtl/fss_pkg.sv =====
// Fade slideshow sequencer: shared types, codes and constants.
// No dependencies; imported by fss_divider, fade_slideshow_sequencer_top and tb.
package fss_pkg;

  // Pool size limit, capped at what an 8-bit title index can address
  localparam int unsigned POOL_MAX = 256;
  localparam int unsigned POOL_CAP = (POOL_MAX > 256) ? 256 : POOL_MAX;

  // Linear congruential generator
  localparam logic [31:0] LCG_MUL   = 32'd1664525;
  localparam logic [31:0] LCG_INC   = 32'd1013904223;
  localparam logic [31:0] RNG_RESET = 32'h0123_4567;

  // Register resets
  localparam logic [15:0] FADE_MS_RESET = 16'd1200;
  localparam logic [15:0] HOLD_MS_RESET = 16'd5000;

  // Hue wheel: 6 segments of 256 steps
  localparam logic [15:0] HUE_PERIOD = 16'd1536;
  localparam logic [7:0]  LEVEL_MAX  = 8'd255;

  // Divider sizes
  localparam int unsigned DIV_DIVIDEND_W = 32;
  localparam int unsigned DIV_DIVISOR_W  = 16;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_DIVIDEND_W);

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POOL_COUNT = 2'd0,
    REG_FADE_MS    = 2'd1,
    REG_HOLD_MS    = 2'd2
  } cfg_reg_t;

  // Ops carried on tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Phase codes
  localparam logic [1:0] PH_FADE_IN  = 2'd0;
  localparam logic [1:0] PH_HOLD     = 2'd1;
  localparam logic [1:0] PH_FADE_OUT = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_IDX_START,
    ST_IDX_WAIT,
    ST_FADE,
    ST_FADE_WAIT,
    ST_HUE,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic                      start;
    logic [DIV_DIVIDEND_W-1:0] dividend;
    logic [DIV_DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic [DIV_DIVIDEND_W-1:0] quotient;
    logic [DIV_DIVISOR_W-1:0]  remainder;
  } div_rsp_t;

endpackage

// ===== hw/rtl/fade_slideshow_sequencer_top.sv =====
// Fade slideshow sequencer, top level.
// Depends on fss_pkg and fss_divider.
//
// Usage: input beats on s_*: s_tuser is the op (start or tick), s_tdata the
//   32-bit millisecond time stamp. Each accepted beat yields exactly one output
//   beat on m_* holding phase, fade level, rainbow colour and current title.
//   Configuration (pool_count, fade_ms, hold_ms) goes in through cfg_wr_en,
//   cfg_index and cfg_data, one register per cycle; the user writes it only
//   while idle, which the block itself does not enforce.
// Flow: one beat at a time; s_tready is high only in idle. The work per beat
//   is the LCG multiply and add and the title modulo when a title is picked,
//   and the fade scaling when the fade level is scaled; the modulo and the
//   scaling each take a pass of the shared radix-2 divider, the hue none.
//   A new beat is taken only after the last item reached the output register.
// Reset (rst, synchronous, active high): generator seed 0x1234567, fade in
//   phase, no title, registers back to pool 0 / 1200 ms / 5000 ms.
// Stall: the result sits in an output register; the next input beat is taken
//   meanwhile, and a finished item waits in its last state until the output
//   register frees up.
module fade_slideshow_sequencer_top (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [31:0]                      s_tdata,  // [31:0] now_ms
  input  logic                             s_tuser,  // [0] op
  // output stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [1:0] phase_out, [9:2] fade_level, [17:10] red, [25:18] green,
  // [33:26] blue, [41:34] title_index, [42] title_valid, [43] new_title,
  // [47:44] zero
  output logic [47:0]                      m_tdata,
  // configuration write port
  input  logic                             cfg_wr_en,
  input  logic [fss_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [15:0]                      cfg_data
);
  import fss_pkg::*;

  // configuration registers
  logic [8:0]  pool_count;
  logic [15:0] fade_ms;
  logic [15:0] hold_ms;

  // architectural state
  logic [31:0] rng_word;
  logic [1:0]  phase;
  logic [31:0] phase_start_ms;
  logic [31:0] enter_ms;
  logic [7:0]  cur_index;
  logic        cur_valid;

  // per-item working registers
  logic [31:0] now_r;
  logic [31:0] prod;
  logic [7:0]  fade_r;
  logic [10:0] hue_r;
  logic        picked;

  seq_state_t state, state_next;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  logic        in_beat;
  logic [8:0]  pool_eff;
  logic [31:0] tick_el;
  logic        pick_req;
  logic [31:0] fade_el;
  logic        fade_div;
  logic [23:0] fade_num;
  logic [31:0] hue_span;
  logic [8:0]  idx_raw;
  logic [8:0]  idx_inc;
  logic [7:0]  idx_sel;
  logic        out_free;
  logic [7:0]  red, green, blue;

  // residue mod 3 of a 20-bit value: base-4 digits each weigh 1 mod 3
  function automatic logic [1:0] mod3_20(input logic [19:0] v);
    logic [4:0] s;  // digit sum, at most 30
    logic [2:0] t;  // at most 7
    logic [2:0] u;  // at most 4
    s = 5'd0;
    for (int i = 0; i < 10; i++) begin
      s = s + {3'd0, v[2*i +: 2]};
    end
    t = {2'd0, s[4]} + {1'b0, s[3:2]} + {1'b0, s[1:0]};
    u = {2'd0, t[2]} + {1'b0, t[1:0]};
    return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
  endfunction

  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // oversized pools saturate to the cap
  assign pool_eff = (pool_count > 9'(POOL_CAP)) ? 9'(POOL_CAP) : pool_count;

  // tick: elapsed time against the stored phase start
  assign tick_el = s_tdata - phase_start_ms;

  always_comb begin
    if (s_tuser == OP_START) begin
      pick_req = 1'b1;
    end else begin
      pick_req = (phase != PH_FADE_IN) && (phase != PH_HOLD) &&
                 (tick_el >= {16'd0, fade_ms});
    end
  end

  // fade level inputs, from the state after the op
  assign fade_el  = now_r - phase_start_ms;
  assign fade_div = (phase != PH_HOLD) && (fade_el < {16'd0, fade_ms});
  // el * 255, el < 2^16 here
  assign fade_num = {fade_el[15:0], 8'd0} - {8'd0, fade_el[15:0]};
  assign hue_span = now_r - enter_ms;

  // title pick: remainder, then step past the current title
  assign idx_raw = {1'b0, div_rsp.remainder[7:0]};
  assign idx_inc = (idx_raw + 9'd1 == pool_eff) ? 9'd0 : idx_raw + 9'd1;
  assign idx_sel = ((pool_eff > 9'd1) && cur_valid && (idx_raw[7:0] == cur_index)) ?
                   idx_inc[7:0] : idx_raw[7:0];

  // rainbow from hue: segment in the top bits, ramp in the low byte
  always_comb begin
    case (hue_r[10:8])
      3'd0: begin
        red = LEVEL_MAX;     green = hue_r[7:0];  blue = 8'd0;
      end
      3'd1: begin
        red = ~hue_r[7:0];   green = LEVEL_MAX;   blue = 8'd0;
      end
      3'd2: begin
        red = 8'd0;          green = LEVEL_MAX;   blue = hue_r[7:0];
      end
      3'd3: begin
        red = 8'd0;          green = ~hue_r[7:0]; blue = LEVEL_MAX;
      end
      3'd4: begin
        red = hue_r[7:0];    green = 8'd0;        blue = LEVEL_MAX;
      end
      default: begin
        red = LEVEL_MAX;     green = 8'd0;        blue = ~hue_r[7:0];
      end
    endcase
  end

  fss_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and divider requests
  always_comb begin
    state_next       = state;
    s_tready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (pick_req && pool_eff != 9'd0) ? ST_MUL : ST_FADE;
        end
      end
      ST_MUL: state_next = ST_ADD;
      ST_ADD: state_next = ST_IDX_START;
      ST_IDX_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = rng_word;
        div_req.divisor  = {7'd0, pool_eff};
        state_next       = ST_IDX_WAIT;
      end
      ST_IDX_WAIT: begin
        if (div_rsp.done) state_next = ST_FADE;
      end
      ST_FADE: begin
        if (fade_div) begin
          div_req.start    = 1'b1;
          div_req.dividend = {8'd0, fade_num};
          div_req.divisor  = fade_ms;
          state_next       = ST_FADE_WAIT;
        end else begin
          state_next = ST_HUE;
        end
      end
      ST_FADE_WAIT: begin
        if (div_rsp.done) state_next = ST_HUE;
      end
      ST_HUE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_count <= 9'd0;
      fade_ms    <= FADE_MS_RESET;
      hold_ms    <= HOLD_MS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_POOL_COUNT: pool_count <= cfg_data[8:0];
        REG_FADE_MS:    fade_ms    <= cfg_data;
        REG_HOLD_MS:    hold_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer state and title selection
  always_ff @(posedge clk) begin
    if (rst) begin
      rng_word       <= RNG_RESET;
      phase          <= PH_FADE_IN;
      phase_start_ms <= 32'd0;
      enter_ms       <= 32'd0;
      cur_index      <= 8'd0;
      cur_valid      <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (s_tuser == OP_START) begin
              enter_ms  <= s_tdata;
              rng_word  <= rng_word ^ (s_tdata | 32'd1);
              cur_valid <= 1'b0;
              cur_index <= 8'd0;
            end else if (phase == PH_FADE_IN) begin
              if (tick_el >= {16'd0, fade_ms}) begin
                phase          <= PH_HOLD;
                phase_start_ms <= s_tdata;
              end
            end else if (phase == PH_HOLD) begin
              if (tick_el >= {16'd0, hold_ms}) begin
                phase          <= PH_FADE_OUT;
                phase_start_ms <= s_tdata;
              end
            end else if (pick_req && pool_eff == 9'd0) begin
              // empty pool: title dropped, phase untouched
              cur_valid <= 1'b0;
              cur_index <= 8'd0;
            end
          end
        end
        ST_ADD: rng_word <= prod + LCG_INC;
        ST_IDX_WAIT: begin
          if (div_rsp.done) begin
            cur_index      <= idx_sel;
            cur_valid      <= 1'b1;
            phase          <= PH_FADE_IN;
            phase_start_ms <= now_r;
          end
        end
        default: ;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        now_r  <= s_tdata;
        picked <= 1'b0;
      end
      ST_MUL: prod <= 32'(rng_word * LCG_MUL);
      ST_IDX_WAIT: begin
        if (div_rsp.done) picked <= 1'b1;
      end
      ST_FADE: begin
        fade_r <= (phase == PH_FADE_IN || phase == PH_HOLD) ? LEVEL_MAX : 8'd0;
      end
      ST_FADE_WAIT: begin
        if (div_rsp.done) begin
          fade_r <= (phase == PH_FADE_IN) ? div_rsp.quotient[7:0] :
                    LEVEL_MAX - div_rsp.quotient[7:0];
        end
      end
      // (span / 8) mod 1536: 512-step blocks taken mod 3, low 9 bits kept
      ST_HUE: hue_r <= {mod3_20(hue_span[31:12]), hue_span[11:3]};
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {4'd0, picked, cur_valid, (cur_valid ? cur_index : 8'd0),
                  blue, green, red, fade_r, phase};
    end
  end

  // checks
  a_no_title_zero_index: assert property (@(posedge clk) disable iff (rst)
    !cur_valid |-> cur_index == 8'd0)
    else $error("title index not cleared without a valid title");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_IDX_WAIT || state == ST_FADE_WAIT))
    else $error("divider finished while the sequencer was not waiting");

  a_phase_code: assert property (@(posedge clk) disable iff (rst)
    phase != 2'd3)
    else $error("reserved phase code reached");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !s_tready)
    else $error("input taken while an item is in progress");

  a_picked_phase: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDX_WAIT && div_rsp.done) |=> phase == PH_FADE_IN && cur_valid)
    else $error("title pick did not restart fade in");

endmodule

// ===== hw/rtl/fss_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on fss_pkg (div_req_t, div_rsp_t, sizes).
module fss_divider (
  input  logic              clk,
  input  logic              rst,
  input  fss_pkg::div_req_t req,
  output fss_pkg::div_rsp_t rsp
);
  import fss_pkg::*;

  logic [DIV_DIVIDEND_W-1:0] quo;
  logic [DIV_DIVISOR_W-1:0]  rem;
  logic [DIV_DIVISOR_W-1:0]  divisor;
  logic [DIV_CNT_W-1:0]      cnt;
  logic                      busy;
  logic                      done;
  logic [DIV_DIVISOR_W:0]    trial;
  logic                      fits;

  assign trial = {rem, quo[DIV_DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      quo <= {quo[DIV_DIVIDEND_W-2:0], fits};
      if (fits) begin
        rem <= DIV_DIVISOR_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[DIV_DIVISOR_W-1:0];
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for fade_slideshow_sequencer_top: start/tick beats in, frames out.
// Depends on fss_pkg and the RTL below it; a predictor inside tracks show state and config.
`timescale 1ns / 100ps

module tb;
  import fss_pkg::*;

  // One output frame, laid out exactly as m_tdata (phase in the low bits)
  typedef struct packed {
    logic [3:0] pad;
    logic       new_title;
    logic       title_valid;
    logic [7:0] title_index;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] fade_level;
    logic [1:0] phase;
  } frame_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [31:0]            s_tdata;   // [31:0] now_ms
  logic                   s_tuser;   // [0] op
  logic                   m_tvalid;
  logic                   m_tready;
  // [1:0] phase_out, [9:2] fade_level, [17:10] red, [25:18] green, [33:26] blue,
  // [41:34] title_index, [42] title_valid, [43] new_title, [47:44] zero
  logic [47:0]            m_tdata;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [15:0]            cfg_data;

  fade_slideshow_sequencer_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the show and of the register file
  // ---------------------------------------------------------------------------
  logic [31:0] seed_word;     // generator word
  logic [1:0]  show_phase;
  logic [31:0] phase_t0;      // when the current phase began
  logic [31:0] saver_t0;      // when the saver was entered (hue origin)
  logic [7:0]  title_cur;
  logic        title_ok;
  logic [8:0]  pool_reg;
  logic [15:0] fade_reg;
  logic [15:0] hold_reg;

  frame_t frames_due[$];      // frames predicted but not yet seen on m_*
  int     fail_count;
  int     idle_pct;           // sender: chance per cycle of holding tvalid low
  int     stall_pct;          // receiver: chance per cycle of holding tready low
  int     hold_off;           // long receiver hold-off, in cycles

  // Draw the next title; an empty pool draws nothing and leaves the phase alone
  function automatic logic draw_title(input logic [31:0] now);
    logic [31:0] pool;
    logic [31:0] idx;
    pool = (pool_reg > POOL_CAP) ? POOL_CAP : {23'd0, pool_reg};
    if (pool == 0) begin
      title_ok  = 1'b0;
      title_cur = 8'd0;
      return 1'b0;
    end
    seed_word = seed_word * LCG_MUL + LCG_INC;
    idx = seed_word % pool;
    // avoid showing the same title twice running
    if (pool > 1 && title_ok && idx == {24'd0, title_cur})
      idx = (idx + 1) % pool;
    title_cur  = idx[7:0];
    title_ok   = 1'b1;
    show_phase = PH_FADE_IN;
    phase_t0   = now;
    return 1'b1;
  endfunction

  // Apply one beat to the predicted show and build the frame it should produce
  function automatic frame_t advance_show(input logic op, input logic [31:0] now);
    frame_t      f;
    logic        picked;
    logic [31:0] el;
    logic [31:0] lvl;
    logic [31:0] hue;
    logic [7:0]  up;
    logic [7:0]  dn;
    picked = 1'b0;
    if (op == OP_START) begin
      saver_t0  = now;
      seed_word = seed_word ^ (now | 32'd1);
      title_ok  = 1'b0;
      title_cur = 8'd0;
      picked    = draw_title(now);
    end else begin
      el = now - phase_t0;
      case (show_phase)
        PH_FADE_IN: begin
          if (el >= fade_reg) begin
            show_phase = PH_HOLD;
            phase_t0   = now;
          end
        end
        PH_HOLD: begin
          if (el >= hold_reg) begin
            show_phase = PH_FADE_OUT;
            phase_t0   = now;
          end
        end
        default: begin
          if (el >= fade_reg) picked = draw_title(now);
        end
      endcase
    end

    // level from time spent in the (possibly new) phase; zero fade never divides
    el = now - phase_t0;
    case (show_phase)
      PH_FADE_IN: lvl = (el >= fade_reg) ? 32'd255 : (el * 32'd255) / fade_reg;
      PH_HOLD:    lvl = 32'd255;
      default:    lvl = (el >= fade_reg) ? 32'd0 : 32'd255 - (el * 32'd255) / fade_reg;
    endcase

    // rainbow wheel: six segments of 256 steps, one step per 8 ms
    hue = ((now - saver_t0) >> 3) % HUE_PERIOD;
    up  = hue[7:0];
    dn  = 8'd255 - up;
    case (hue / 256)
      0:       begin f.red = 8'd255; f.green = up;     f.blue = 8'd0;   end
      1:       begin f.red = dn;     f.green = 8'd255; f.blue = 8'd0;   end
      2:       begin f.red = 8'd0;   f.green = 8'd255; f.blue = up;     end
      3:       begin f.red = 8'd0;   f.green = dn;     f.blue = 8'd255; end
      4:       begin f.red = up;     f.green = 8'd0;   f.blue = 8'd255; end
      default: begin f.red = 8'd255; f.green = 8'd0;   f.blue = dn;     end
    endcase

    f.pad         = 4'd0;
    f.phase       = show_phase;
    f.fade_level  = lvl[7:0];
    f.title_index = title_ok ? title_cur : 8'd0;
    f.title_valid = title_ok;
    f.new_title   = picked;
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  // Register write; only called with the block idle
  task automatic write_reg(input cfg_reg_t which, input logic [15:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = which;
    cfg_data  = value;
    case (which)
      REG_POOL_COUNT: pool_reg = value[8:0];
      REG_FADE_MS:    fade_reg = value;
      default:        hold_reg = value;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Offer one beat, wait for the handshake, predict its frame on acceptance.
  // tvalid stays high on return so back-to-back beats need no toggle.
  task automatic send_item(input logic op, input logic [31:0] now);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = now;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    frames_due.push_back(advance_show(op, now));
    @(negedge clk);
  endtask

  // Drop tvalid and wait for every predicted frame to come out
  task automatic settle();
    s_tvalid = 1'b0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One full slide: fade in, hold, fade out and on to the next title
  task automatic walk_cycle(input logic [31:0] t0);
    logic [31:0] t;
    t = t0;
    send_item(OP_START, t);
    send_item(OP_TICK, t + fade_reg / 2);
    t = t + fade_reg;
    send_item(OP_TICK, t);
    send_item(OP_TICK, t + hold_reg / 2);
    t = t + hold_reg;
    send_item(OP_TICK, t);
    send_item(OP_TICK, t + fade_reg / 2);
    send_item(OP_TICK, t + fade_reg);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here
  // ---------------------------------------------------------------------------
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        m_tready = 1'b0;
        hold_off = hold_off - 1;
      end else begin
        m_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Frame checker, sampled on the rising edge
  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (frames_due.size() == 0) begin
        $error("output beat with no frame expected: %h", m_tdata);
        fail_count++;
      end else begin
        want = frames_due.pop_front();
        check_field("phase_out",   want.phase,       got.phase);
        check_field("fade_level",  want.fade_level,  got.fade_level);
        check_field("red",         want.red,         got.red);
        check_field("green",       want.green,       got.green);
        check_field("blue",        want.blue,        got.blue);
        check_field("title_index", want.title_index, got.title_index);
        check_field("title_valid", want.title_valid, got.title_valid);
        check_field("new_title",   want.new_title,   got.new_title);
        check_field("pad",         want.pad,         got.pad);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ticks with no start yet, then a start into an empty pool
  task automatic test_reset_state();
    send_item(OP_TICK, 32'd0);
    send_item(OP_TICK, 32'd1300);   // past the default fade: into hold, no title
    send_item(OP_START, 32'd7);     // empty pool: phase stays in hold
  endtask

  // Two titles, default lengths, time stamps wrapping through zero
  task automatic test_title_cycle();
    settle();
    write_reg(REG_POOL_COUNT, 16'd2);
    walk_cycle(32'hFFFF_FC00);
  endtask

  // Oversized pool saturates; zero lengths make every phase end at once
  task automatic test_zero_lengths();
    settle();
    write_reg(REG_POOL_COUNT, 16'd511);
    write_reg(REG_FADE_MS, 16'd0);
    write_reg(REG_HOLD_MS, 16'd0);
    send_item(OP_START, 32'hFFFF_FFFF);
    repeat (3) send_item(OP_TICK, 32'hFFFF_FFFF);
  endtask

  // Single title, longest fade and hold
  task automatic test_long_lengths();
    settle();
    write_reg(REG_POOL_COUNT, 16'd1);
    write_reg(REG_FADE_MS, 16'hFFFF);
    write_reg(REG_HOLD_MS, 16'hFFFF);
    walk_cycle(32'd0);
  endtask

  // Full pool, 1 ms phases
  task automatic test_unit_lengths();
    settle();
    write_reg(REG_POOL_COUNT, 16'd256);
    write_reg(REG_FADE_MS, 16'd1);
    write_reg(REG_HOLD_MS, 16'd1);
    send_item(OP_START, 32'hAAAA_5555);
    send_item(OP_TICK, 32'hAAAA_5556);
    send_item(OP_TICK, 32'hAAAA_5557);
    send_item(OP_TICK, 32'hAAAA_5558);
  endtask

  // Random setting, then mostly rising time stamps so phases run their course;
  // a few restarts and wild time stamps break the pattern
  task automatic test_random_show(input int n, input int s_idle, input int r_stall);
    logic [31:0] now;
    logic [31:0] span;
    int          k;
    settle();
    idle_pct  = s_idle;
    stall_pct = r_stall;
    case ($urandom_range(9))
      0:       write_reg(REG_POOL_COUNT, 16'd0);
      1:       write_reg(REG_POOL_COUNT, 16'd1);
      2:       write_reg(REG_POOL_COUNT, 16'd2);
      3:       write_reg(REG_POOL_COUNT, 16'($urandom_range(3, 8)));
      7:       write_reg(REG_POOL_COUNT, 16'd256);
      8:       write_reg(REG_POOL_COUNT, 16'($urandom_range(257, 511)));
      default: write_reg(REG_POOL_COUNT, 16'($urandom_range(3, 255)));
    endcase
    case ($urandom_range(7))
      0:       write_reg(REG_FADE_MS, 16'd0);
      1:       write_reg(REG_FADE_MS, 16'hFFFF);
      default: write_reg(REG_FADE_MS, 16'($urandom_range(1, 400)));
    endcase
    case ($urandom_range(7))
      0:       write_reg(REG_HOLD_MS, 16'd0);
      1:       write_reg(REG_HOLD_MS, 16'hFFFF);
      default: write_reg(REG_HOLD_MS, 16'($urandom_range(0, 600)));
    endcase
    span = ((fade_reg > hold_reg) ? fade_reg : hold_reg) / 3 + 2;
    now  = $urandom();
    if ($urandom_range(9) != 0) begin
      send_item(OP_START, now);
      n = n - 1;
    end
    repeat (n) begin
      k = $urandom_range(99);
      if (k < 5) begin
        send_item(OP_START, now);
      end else if (k < 10) begin
        send_item(OP_TICK, $urandom());
      end else begin
        now = now + $urandom_range(0, span);
        send_item(OP_TICK, now);
      end
    end
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    logic [31:0] now;
    settle();
    idle_pct  = 0;
    stall_pct = 0;
    hold_off  = 300;
    now       = $urandom();
    send_item(OP_START, now);
    repeat (15) begin
      now = now + $urandom_range(0, 200);
      send_item(OP_TICK, now);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tuser    = OP_START;
    s_tdata    = 32'd0;
    cfg_wr_en  = 1'b0;
    cfg_index  = REG_POOL_COUNT;
    cfg_data   = 16'd0;
    fail_count = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_off   = 0;
    // predictor reset state
    seed_word  = RNG_RESET;
    show_phase = PH_FADE_IN;
    phase_t0   = 32'd0;
    saver_t0   = 32'd0;
    title_cur  = 8'd0;
    title_ok   = 1'b0;
    pool_reg   = 9'd0;
    fade_reg   = FADE_MS_RESET;
    hold_reg   = HOLD_MS_RESET;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_title_cycle();
    test_zero_lengths();
    test_long_lengths();
    test_unit_lengths();
    test_random_show(95, 0, 0);
    test_random_show(95, 52, 0);
    test_random_show(95, 0, 52);
    test_random_show(95, 20, 20);
    test_backpressure();

    settle();
    // allow a worst-case item time for any stray beat to show up
    repeat (120) @(negedge clk);
    if (fail_count == 0)
      $display("fade_slideshow_sequencer_top: match");
    else
      $display("fade_slideshow_sequencer_top: mismatch");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2000000;
    $display("fade_slideshow_sequencer_top: mismatch");
    $finish;
  end

endmodule
